// ===== hdl/depth_tested_pixel_to_console_cell_assert.svh =====
// ----------------------------------------------------------------------------
// Depth-tested pixel to console cell: assertion macros
// Short forms for clocked assertions with a reset guard (disable iff).
// ----------------------------------------------------------------------------
`ifndef DEPTH_TESTED_PIXEL_TO_CONSOLE_CELL_ASSERT_SVH
`define DEPTH_TESTED_PIXEL_TO_CONSOLE_CELL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dtpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtpc_pkg
// Shared types, sizes and thresholds of the depth-tested console cell block.
// ----------------------------------------------------------------------------
package dtpc_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int XW          = $clog2(MAX_WIDTH);
  localparam int YW          = $clog2(MAX_HEIGHT);

  localparam int POS_W   = 12;
  localparam int DEPTH_W = 16;
  localparam int CHAN_W  = 8;
  localparam int CELL_W  = 13;
  localparam int PROD_W  = 2 * CHAN_W;
  localparam int SQ_W    = 2 * PROD_W;
  localparam int LUM_W   = 42;
  localparam int COEF_W  = 10;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int SW_W       = 8;
  localparam int SH_W       = 7;
  localparam logic [SW_W-1:0] SCREEN_WIDTH_RST  = 8'd80;
  localparam logic [SH_W-1:0] SCREEN_HEIGHT_RST = 7'd25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                      mode;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [DEPTH_W-1:0] depth;
    logic [CHAN_W-1:0]         red;
    logic [CHAN_W-1:0]         green;
    logic [CHAN_W-1:0]         blue;
    logic [CHAN_W-1:0]         weight;
  } pixel_t;

  typedef struct packed {
    logic              written;
    logic [CELL_W-1:0] cell_index;
    logic [7:0]        glyph;
    logic [7:0]        attribute;
  } result_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic [7:0] attribute;
  } shade_t;

  // Luminance weights, scaled by 1000.
  localparam logic [COEF_W-1:0] LUM_COEF_R = 10'd299;
  localparam logic [COEF_W-1:0] LUM_COEF_G = 10'd587;
  localparam logic [COEF_W-1:0] LUM_COEF_B = 10'd114;

  // Full scale of a squared channel product: 65025 squared.
  localparam logic [63:0] FULL_SQ = 64'd4228250625;

  // Strict thresholds: value > T is the same as the exact rational test.
  localparam logic [63:0] LUM_HI_T64 = 64'd443556000 * FULL_SQ / 64'd1000000;
  localparam logic [63:0] LUM_LO_T64 = 64'd110889000 * FULL_SQ / 64'd1000000;
  localparam logic [LUM_W-1:0] LUM_HI_T = LUM_W'(LUM_HI_T64);
  localparam logic [LUM_W-1:0] LUM_LO_T = LUM_W'(LUM_LO_T64);

  localparam logic [PROD_W-1:0] CH_HI_T = PROD_W'(64'd43306650 / 64'd1000);
  localparam logic [PROD_W-1:0] CH_LO_T = PROD_W'(64'd21653325 / 64'd1000);

  // Glyph steps: lum >= G_k is the same as lum * 4.015^2 >= k^2 (rounded up).
  localparam logic [63:0] GLYPH_MUL  = 64'd644809;
  localparam logic [63:0] GLYPH_UNIT = 64'd40000000 * FULL_SQ;
  localparam logic [LUM_W-1:0] GLYPH_T1 =
    LUM_W'((64'd1 * GLYPH_UNIT + GLYPH_MUL - 64'd1) / GLYPH_MUL);
  localparam logic [LUM_W-1:0] GLYPH_T2 =
    LUM_W'((64'd4 * GLYPH_UNIT + GLYPH_MUL - 64'd1) / GLYPH_MUL);
  localparam logic [LUM_W-1:0] GLYPH_T3 =
    LUM_W'((64'd9 * GLYPH_UNIT + GLYPH_MUL - 64'd1) / GLYPH_MUL);
  localparam logic [LUM_W-1:0] GLYPH_T4 =
    LUM_W'((64'd16 * GLYPH_UNIT + GLYPH_MUL - 64'd1) / GLYPH_MUL);

  localparam logic [7:0] SHADE_CODES [5] = '{8'h00, 8'hB0, 8'hB1, 8'hB2, 8'hDB};

  localparam logic [7:0] ATTR_LUM_HI   = 8'h88;
  localparam logic [7:0] ATTR_LUM_LO   = 8'h08;
  localparam logic [7:0] ATTR_RED_HI   = 8'h44;
  localparam logic [7:0] ATTR_RED_LO   = 8'h04;
  localparam logic [7:0] ATTR_GREEN_HI = 8'h22;
  localparam logic [7:0] ATTR_GREEN_LO = 8'h02;
  localparam logic [7:0] ATTR_BLUE_HI  = 8'h11;
  localparam logic [7:0] ATTR_BLUE_LO  = 8'h01;

endpackage

// ===== hdl/dtpc_ram.sv =====
// ----------------------------------------------------------------------------
// dtpc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dtpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/dtpc_shade.sv =====
// ----------------------------------------------------------------------------
// dtpc_shade
// Colour pipeline: weighted channels, squared luminance, glyph and attribute.
// ----------------------------------------------------------------------------
module dtpc_shade (
  input  logic             clk,
  input  logic             load,
  input  dtpc_pkg::pixel_t pixel,
  output dtpc_pkg::shade_t shade
);
  import dtpc_pkg::*;

  logic [PROD_W-1:0] p_red;
  logic [PROD_W-1:0] p_green;
  logic [PROD_W-1:0] p_blue;
  logic [SQ_W-1:0]   sq_red;
  logic [SQ_W-1:0]   sq_green;
  logic [SQ_W-1:0]   sq_blue;
  logic [7:0]        ch_attr;
  logic [LUM_W-1:0]  lum;
  logic [7:0]        lum_attr;
  logic [2:0]        level;

  // The first stage holds the products for the whole item; later stages
  // run freely and settle on it through the square and luminance registers.
  always_ff @(posedge clk) begin
    if (load) begin
      p_red   <= PROD_W'(pixel.red)   * PROD_W'(pixel.weight);
      p_green <= PROD_W'(pixel.green) * PROD_W'(pixel.weight);
      p_blue  <= PROD_W'(pixel.blue)  * PROD_W'(pixel.weight);
    end
  end

  always_ff @(posedge clk) begin
    sq_red   <= SQ_W'(p_red)   * SQ_W'(p_red);
    sq_green <= SQ_W'(p_green) * SQ_W'(p_green);
    sq_blue  <= SQ_W'(p_blue)  * SQ_W'(p_blue);
    ch_attr  <= ((p_red   > CH_HI_T) ? ATTR_RED_HI   :
                 (p_red   > CH_LO_T) ? ATTR_RED_LO   : 8'h00) |
                ((p_green > CH_HI_T) ? ATTR_GREEN_HI :
                 (p_green > CH_LO_T) ? ATTR_GREEN_LO : 8'h00) |
                ((p_blue  > CH_HI_T) ? ATTR_BLUE_HI  :
                 (p_blue  > CH_LO_T) ? ATTR_BLUE_LO  : 8'h00);
  end

  always_ff @(posedge clk) begin
    lum <= LUM_W'(LUM_COEF_R) * LUM_W'(sq_red)
         + LUM_W'(LUM_COEF_G) * LUM_W'(sq_green)
         + LUM_W'(LUM_COEF_B) * LUM_W'(sq_blue);
  end

  always_comb begin
    if (lum > LUM_HI_T) begin
      lum_attr = ATTR_LUM_HI;
    end else if (lum > LUM_LO_T) begin
      lum_attr = ATTR_LUM_LO;
    end else begin
      lum_attr = 8'h00;
    end

    if (lum >= GLYPH_T4) begin
      level = 3'd4;
    end else if (lum >= GLYPH_T3) begin
      level = 3'd3;
    end else if (lum >= GLYPH_T2) begin
      level = 3'd2;
    end else if (lum >= GLYPH_T1) begin
      level = 3'd1;
    end else begin
      level = 3'd0;
    end

    shade.glyph     = SHADE_CODES[level];
    shade.attribute = lum_attr | ch_attr;
  end

endmodule

// ===== hdl/depth_tested_pixel_to_console_cell.sv =====
// ----------------------------------------------------------------------------
// depth_tested_pixel_to_console_cell
// Culls screen pixels, runs a z-buffer test and maps colour to a console cell.
// ----------------------------------------------------------------------------
// A plot word passes from acceptance through depth RAM read, test and
// write-back, and result load; the block takes no new word until that result
// is loaded. A culled pixel skips the RAM. The pace is set by the
// read-modify-write of the single depth RAM. A clear word sweeps the
// 8192-entry depth RAM one entry a cycle and then gives its result. After
// reset the same clearing pass runs before the first pixel word is accepted;
// configuration writes are taken at any time.
`include "depth_tested_pixel_to_console_cell_assert.svh"

module depth_tested_pixel_to_console_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_ready,
  input  dtpc_pkg::pixel_t                    pixel,
  output logic                                result_valid,
  input  logic                                result_ready,
  output dtpc_pkg::result_t                   result,
  input  logic                                cfg_write,
  input  logic [dtpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dtpc_pkg::*;

  state_t state;
  state_t state_next;

  logic [SW_W-1:0]    screen_width;
  logic [SH_W-1:0]    screen_height;
  logic [POS_W-1:0]   w_eff;
  logic [POS_W-1:0]   h_eff;
  logic               hit;
  logic [ADDR_W-1:0]  idx;
  logic               accept;

  logic [ADDR_W-1:0]  addr;
  logic [DEPTH_W-1:0] dz;
  logic               wr_ok;
  logic               depth_ok;
  logic [ADDR_W-1:0]  clr_cnt;
  logic               clr_last;
  logic               clr_item;

  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [DEPTH_W-1:0] ram_rdata;
  logic               load_result;
  dtpc_pkg::shade_t   shade;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[SW_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[SH_W-1:0];
      endcase
    end
  end

  // Culling and cell index from the incoming word
  always_comb begin
    w_eff = (POS_W'(screen_width) < POS_W'(MAX_WIDTH)) ?
            POS_W'(screen_width) : POS_W'(MAX_WIDTH);
    h_eff = (POS_W'(screen_height) < POS_W'(MAX_HEIGHT)) ?
            POS_W'(screen_height) : POS_W'(MAX_HEIGHT);
    hit = !pixel.pos_x[POS_W-1] && !pixel.pos_y[POS_W-1] &&
          !pixel.depth[DEPTH_W-1] &&
          (POS_W'(pixel.pos_x[POS_W-2:0]) < w_eff) &&
          (POS_W'(pixel.pos_y[POS_W-2:0]) < h_eff);
    idx = ADDR_W'(ADDR_W'(pixel.pos_y[YW-1:0]) * ADDR_W'(w_eff)
                  + ADDR_W'(pixel.pos_x[XW-1:0]));
  end

  assign accept   = pixel_valid && pixel_ready;
  assign clr_last = (clr_cnt == ADDR_W'(STORE_DEPTH - 1));
  assign depth_ok = (ram_rdata == '0) || (dz <= ram_rdata);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_last) begin
          state_next = clr_item ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (pixel.mode) begin
            state_next = ST_CLEAR;
          end else if (hit) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!result_valid || result_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pixel_ready = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = addr;
    load_result = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      ST_IDLE:   pixel_ready = 1'b1;
      ST_READ:   ram_re = 1'b1;
      ST_CHECK:  ram_we = depth_ok;
      ST_FINISH: load_result = !result_valid || result_ready;
      default: begin
        pixel_ready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      clr_item     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end else if (accept) begin
        clr_cnt  <= '0;
        clr_item <= pixel.mode;
      end
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      addr  <= idx;
      dz    <= pixel.depth;
      wr_ok <= 1'b0;
    end else if (state == ST_CHECK) begin
      wr_ok <= depth_ok;
    end
    if (load_result) begin
      result.written    <= wr_ok;
      result.cell_index <= wr_ok ? CELL_W'(addr) : '0;
      result.glyph      <= wr_ok ? shade.glyph : 8'h00;
      result.attribute  <= wr_ok ? shade.attribute : 8'h00;
    end
  end

  dtpc_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (STORE_DEPTH)
  ) u_depth_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ((state == ST_CLEAR) ? '0 : dz),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  dtpc_shade u_shade (
    .clk   (clk),
    .load  (accept),
    .pixel (pixel),
    .shade (shade)
  );

  `DTPC_ASSERT_NEXT(a_clear_starts, clk, rst,
    accept && pixel.mode, state == ST_CLEAR && clr_cnt == '0,
    "clear word did not start a sweep at entry zero")

  `DTPC_ASSERT_NEXT(a_sweep_steps, clk, rst,
    state == ST_CLEAR && !clr_last, state == ST_CLEAR && clr_cnt == $past(clr_cnt) + ADDR_W'(1),
    "clearing sweep skipped or left early")

  `DTPC_ASSERT_NOW(a_reject_blank, clk, rst,
    result_valid && !result.written,
    result.cell_index == '0 && result.glyph == 8'h00 && result.attribute == 8'h00,
    "rejected result carries nonzero fields")

endmodule

// ===== bench/console_cell_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// console_cell_checker
// Watches the pixel, result and register ports of the console cell block. It
// keeps its own depth buffer and screen size, works out the cell that each
// accepted pixel word should give, and compares every result word with it.
// ----------------------------------------------------------------------------
module console_cell_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  input  logic                            pixel_ready,
  input  dtpc_pkg::pixel_t                pixel,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  dtpc_pkg::result_t               result,
  input  logic                            cfg_write,
  input  logic [dtpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtpc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              cells_owed,
  output int                              mismatches
);
  import dtpc_pkg::*;

  // 65025 squared: the full scale of a squared channel product.
  localparam longint unsigned FULL_SCALE_SQ = 64'd4228250625;

  logic [DEPTH_W-1:0] zbuf [STORE_DEPTH];
  logic [SW_W-1:0]    width_reg;
  logic [SH_W-1:0]    height_reg;
  result_t            cells_due [$];
  result_t            due;

  function automatic logic [7:0] channel_attr(input longint unsigned prod,
                                              input logic [7:0] hi_bits,
                                              input logic [7:0] lo_bits);
    if (prod * 1000 > 64'd666 * 64'd65025) return hi_bits;
    if (prod * 1000 > 64'd333 * 64'd65025) return lo_bits;
    return 8'h00;
  endfunction

  // Runs one pixel word against the depth buffer and returns its cell.
  function automatic result_t predict_cell(input pixel_t p);
    result_t         r;
    int unsigned     w, h, x, y, idx, lvl;
    longint unsigned pr, pg, pb, lum;
    r = '0;
    w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    if (p.mode) begin
      foreach (zbuf[i]) zbuf[i] = '0;
      return r;
    end
    if (p.pos_x < 0 || p.pos_y < 0 || p.depth < 0) return r;
    x = p.pos_x;
    y = p.pos_y;
    if (x >= w || y >= h) return r;
    idx = y * w + x;
    if (zbuf[idx] != 0 && p.depth > zbuf[idx]) return r;
    zbuf[idx] = p.depth;

    pr  = 64'(p.red) * 64'(p.weight);
    pg  = 64'(p.green) * 64'(p.weight);
    pb  = 64'(p.blue) * 64'(p.weight);
    lum = 299 * pr * pr + 587 * pg * pg + 114 * pb * pb;

    // Luminance squared against 0.666 and 0.333 squared.
    if (lum * 1000 > 64'd443556 * FULL_SCALE_SQ) r.attribute = ATTR_LUM_HI;
    else if (lum * 1000 > 64'd110889 * FULL_SCALE_SQ) r.attribute = ATTR_LUM_LO;
    r.attribute |= channel_attr(pr, ATTR_RED_HI, ATTR_RED_LO);
    r.attribute |= channel_attr(pg, ATTR_GREEN_HI, ATTR_GREEN_LO);
    r.attribute |= channel_attr(pb, ATTR_BLUE_HI, ATTR_BLUE_LO);

    // Shade level is floor(l * 4.015); 4.015 squared is 644809 / 40000.
    lvl = 0;
    for (int k = 1; k <= 4; k++) begin
      if (lum * 644809 >= 64'(k * k) * 64'd40000000 * FULL_SCALE_SQ) lvl = k;
    end

    r.written    = 1'b1;
    r.cell_index = CELL_W'(idx);
    r.glyph      = SHADE_CODES[lvl];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (zbuf[i]) zbuf[i] = '0;
      width_reg  = SCREEN_WIDTH_RST;
      height_reg = SCREEN_HEIGHT_RST;
      cells_due.delete();
      cells_owed = 0;
      mismatches = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_SCREEN_WIDTH) width_reg = SW_W'(cfg_data);
        else if (cfg_index == REG_SCREEN_HEIGHT) height_reg = SH_W'(cfg_data);
      end
      if (pixel_valid && pixel_ready) cells_due.push_back(predict_cell(pixel));
      if (result_valid && result_ready) begin
        if (cells_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word %h arrived with no pixel pending", $time, result);
          mismatches++;
        end else begin
          due = cells_due.pop_front();
          if (result.written !== due.written || result.cell_index !== due.cell_index ||
              result.glyph !== due.glyph || result.attribute !== due.attribute) begin
            if (mismatches < 10) begin
              $display("%0t: cell mismatch (expected/actual)", $time);
              $display("  written %b/%b index %0d/%0d glyph %h/%h attribute %h/%h",
                       due.written, result.written, due.cell_index, result.cell_index,
                       due.glyph, result.glyph, due.attribute, result.attribute);
            end
            mismatches++;
          end
        end
      end
      cells_owed = cells_due.size();
    end
  end

endmodule

// ===== bench/depth_tested_pixel_to_console_cell_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_tested_pixel_to_console_cell_tb
// Drives pixel words and screen sizes into the console cell block and leaves
// prediction and comparison to the checker. A directed opening covers culling
// edges, depth ordering, empty cells, clears and colour thresholds; random
// words then run over a series of screen sizes under shifting back-pressure.
// ----------------------------------------------------------------------------
module depth_tested_pixel_to_console_cell_tb;
  import dtpc_pkg::*;

  localparam int QUIET_LIMIT = 50000;
  localparam int NUM_SIZES   = 9;
  localparam int PER_SIZE    = 181;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  pixel_valid = 1'b0;
  logic                  pixel_ready;
  pixel_t                pixel = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int cells_owed, mismatches;
  int send_idle_pct = 10;
  int recv_idle_pct = 65;
  int hold_len      = 0;
  int burst_left    = 0;
  int cur_w         = 80;
  int cur_h         = 25;
  int quiet_cycles  = 0;
  int words_sent    = 0;
  int clears_sent   = 0;
  int cells_seen    = 0;
  int size_w [NUM_SIZES] = '{16, 128, 1, 255, 0, 9, 40, 3, 128};
  int size_h [NUM_SIZES] = '{8, 64, 1, 127, 12, 0, 30, 64, 1};

  always #5 clk = ~clk;

  depth_tested_pixel_to_console_cell u_top (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  console_cell_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cells_owed   (cells_owed),
    .mismatches   (mismatches)
  );

  // A long hold is timed here so that the sender keeps offering words meanwhile.
  always begin
    @(negedge clk);
    if (hold_len > 0) begin
      result_ready <= 1'b0;
      repeat (hold_len) @(negedge clk);
      hold_len = 0;
    end
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (result_valid && result_ready) cells_seen <= cells_seen + 1;
    if ((pixel_valid && pixel_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic pixel_t pixel_word(input int mode, input int x, input int y,
                                        input int d, input int r, input int g,
                                        input int b, input int w);
    pixel_t p;
    p.mode   = 1'(mode);
    p.pos_x  = POS_W'(x);
    p.pos_y  = POS_W'(y);
    p.depth  = DEPTH_W'(d);
    p.red    = CHAN_W'(r);
    p.green  = CHAN_W'(g);
    p.blue   = CHAN_W'(b);
    p.weight = CHAN_W'(w);
    return p;
  endfunction

  // Mostly on-screen plots, half of them packed into a small corner so that cells
  // are hit again, with off-screen positions, raw noise and the odd clear mixed in.
  function automatic pixel_t random_pixel();
    pixel_t      p;
    int unsigned pick, ew, eh;
    ew = (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
    eh = (cur_h > MAX_HEIGHT) ? MAX_HEIGHT : cur_h;
    p = '0;
    p.red   = CHAN_W'($urandom);
    p.green = CHAN_W'($urandom);
    p.blue  = CHAN_W'($urandom);
    pick = $urandom_range(9);
    if (pick < 3) p.weight = 8'hFF;
    else if (pick == 3) p.weight = 8'h00;
    else p.weight = CHAN_W'($urandom);
    pick = $urandom_range(999);
    if (pick < 7) begin
      p.mode  = 1'b1;
      p.pos_x = POS_W'($urandom);
      p.pos_y = POS_W'($urandom);
      p.depth = DEPTH_W'($urandom);
    end else if (pick < 780 && ew > 0 && eh > 0) begin
      if ($urandom_range(1)) begin
        p.pos_x = POS_W'($urandom_range((ew < 4 ? ew : 4) - 1));
        p.pos_y = POS_W'($urandom_range((eh < 4 ? eh : 4) - 1));
      end else begin
        p.pos_x = POS_W'($urandom_range(ew - 1));
        p.pos_y = POS_W'($urandom_range(eh - 1));
      end
      pick = $urandom_range(9);
      if (pick == 0) p.depth = '0;
      else if (pick < 6) p.depth = DEPTH_W'($urandom_range(40));
      else p.depth = DEPTH_W'($urandom_range(32767));
    end else if (pick < 900) begin
      p.pos_x = POS_W'($urandom_range((ew > 0) ? ew - 1 : 0));
      p.pos_y = POS_W'($urandom_range((eh > 0) ? eh - 1 : 0));
      if ($urandom_range(1)) begin
        if ($urandom_range(1)) p.pos_x = POS_W'(ew + $urandom_range(2047 - ew));
        else p.pos_x = POS_W'(0 - int'($urandom_range(2048, 1)));
      end else begin
        if ($urandom_range(1)) p.pos_y = POS_W'(eh + $urandom_range(2047 - eh));
        else p.pos_y = POS_W'(0 - int'($urandom_range(2048, 1)));
      end
      p.depth = DEPTH_W'($urandom_range(32767));
    end else begin
      p.pos_x = POS_W'($urandom);
      p.pos_y = POS_W'($urandom);
      p.depth = DEPTH_W'($urandom);
    end
    return p;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back words need no extra edge.
  task automatic push_pixel(input pixel_t p);
    int idle_pct;
    idle_pct = (burst_left > 0) ? 0 : send_idle_pct;
    if (burst_left > 0) burst_left--;
    if ($urandom_range(99) < idle_pct) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    pixel       <= p;
    pixel_valid <= 1'b1;
    words_sent++;
    if (p.mode) clears_sent++;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    pixel_valid <= 1'b0;
    while (cells_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_screen(input int w, input int h);
    cfg_write <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= CFG_DATA_W'(w);
    @(negedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h);
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_w = w;
    cur_h = h & 8'h7F;
  endtask

  initial begin
    int done;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words on the reset screen of 80 by 25.
    push_pixel(pixel_word(0, 0, 0, 100, 255, 255, 255, 255));
    push_pixel(pixel_word(0, 0, 0, 200, 255, 255, 255, 255));   // farther: rejected
    push_pixel(pixel_word(0, 0, 0, 100, 10, 20, 30, 255));      // equal depth passes
    push_pixel(pixel_word(0, 0, 0, 50, 0, 0, 0, 0));
    push_pixel(pixel_word(0, 79, 24, 32767, 255, 0, 0, 255));
    push_pixel(pixel_word(0, 78, 24, 1000, 0, 255, 0, 255));
    push_pixel(pixel_word(0, 77, 24, 1000, 0, 0, 255, 255));
    push_pixel(pixel_word(0, 80, 0, 5, 255, 255, 255, 255));
    push_pixel(pixel_word(0, 0, 25, 5, 255, 255, 255, 255));
    push_pixel(pixel_word(0, -1, 3, 5, 255, 255, 255, 255));
    push_pixel(pixel_word(0, -2048, -2048, 5, 255, 255, 255, 255));
    push_pixel(pixel_word(0, 2047, 2047, 5, 255, 255, 255, 255));
    push_pixel(pixel_word(0, 3, 3, -1, 255, 255, 255, 255));
    push_pixel(pixel_word(0, 3, 3, -32768, 255, 255, 255, 255));
    // A zero depth leaves the cell empty, so the far word after it lands.
    push_pixel(pixel_word(0, 5, 5, 0, 170, 169, 128, 255));
    push_pixel(pixel_word(0, 5, 5, 32767, 255, 255, 255, 0));
    push_pixel(pixel_word(0, 6, 6, 300, 200, 200, 200, 128));
    push_pixel(pixel_word(1, 2047, -1, -1, 255, 255, 255, 255));
    push_pixel(pixel_word(0, 0, 0, 16383, 255, 255, 255, 255));
    push_pixel(pixel_word(0, 0, 0, 16384, 255, 255, 255, 255));
    push_pixel(pixel_word(0, 1, 0, 16'h4000, 100, 150, 200, 200));

    done = 0;
    for (int s = 0; s < NUM_SIZES; s++) begin
      drain();
      set_screen(size_w[s], size_h[s]);
      for (int i = 0; i < PER_SIZE; i++) begin
        if (done < PER_SIZE * NUM_SIZES / 3) begin
          send_idle_pct = 10;
          recv_idle_pct = 65;
        end else if (done < 2 * PER_SIZE * NUM_SIZES / 3) begin
          send_idle_pct = 65;
          recv_idle_pct = 10;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        // Hold the result side off while words keep coming, to back up the block.
        if (s == 1 && i == 0) begin
          hold_len   = 400;
          burst_left = 40;
        end
        if (i == PER_SIZE / 2) drain();
        push_pixel(random_pixel());
        done++;
      end
    end

    drain();
    repeat (20) @(negedge clk);
    $display("summary: %0d pixel words including %0d clears over %0d screen sizes,",
             words_sent, clears_sent, NUM_SIZES + 1);
    $display("summary: %0d result words checked, %0d mismatches", cells_seen, mismatches);
    if (mismatches == 0 && cells_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/dtpc_pkg.sv
hdl/dtpc_ram.sv
hdl/dtpc_shade.sv
hdl/depth_tested_pixel_to_console_cell.sv
bench/console_cell_checker.sv
bench/depth_tested_pixel_to_console_cell_tb.sv
